>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: depth, widths, opcodes and status codes.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned Depth  = 8;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned HeldW  = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic ins;  // insert accepted and there is room
    logic rem;  // remove accepted and store not empty
  } cell_ctrl_t;

endpackage

>>> rtl/spq_if.sv
// Channel interfaces of the sorted priority queue: request and response words.
// Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  spq_pkg::data_t        item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
  modport mon    (input valid, input opcode, input item_value, input ready);
endinterface

interface spq_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  spq_pkg::data_t            removed_value;
  logic [spq_pkg::HeldW-1:0] held_count;

  modport source (output valid, output status, output removed_value, output held_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input held_count,
                  output ready);
  modport mon    (input valid, input status, input removed_value, input held_count,
                  input ready);
endinterface

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds a value, compares against the incoming
// item, and takes its left or right neighbor's value on insert or remove. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                live_i,
  input  spq_pkg::data_t      item_i,
  input  logic                prev_shift_i,
  input  spq_pkg::data_t      prev_value_i,
  input  spq_pkg::data_t      next_value_i,
  output logic                shift_o,
  output spq_pkg::data_t      value_o
);
  import spq_pkg::*;

  data_t value_q, value_d;

  // A free slot acts as +infinity, so the first free slot takes the insert.
  assign shift_o = !live_i || (item_i < value_q);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && shift_o) begin
      value_d = prev_shift_i ? prev_value_i : item_i;
    end else if (ctrl_i.rem) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue top level: chain of spq_cell slots, count and response register.
// Depends on spq_pkg, spq_if (spq_in_if, spq_out_if) and spq_cell.
`timescale 1ns / 1ps

// Holds up to Depth (8) signed 32-bit values in ascending order in a row of
// cells. Every request word (insert or remove-smallest) gets exactly one
// response word in the cycle after it is accepted, carrying status, removed
// value and the count held afterwards. All cells compare the item against
// their own value in parallel and shift one place in the same cycle, so a
// new request is taken every cycle; the response register only holds off
// requests while its word is stalled on the output side. Equal values leave
// in arrival order. Insert on a full store returns status full, remove on an
// empty store returns status empty; neither changes the contents.
module sorted_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  cnt_t       cnt_q, cnt_d;
  logic       out_valid_q;
  status_e    status_q, status_d;
  data_t      removed_q, removed_d;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full, empty;

  data_t      value  [Depth];
  logic       shift  [Depth];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);

  assign ctrl.ins = accept && (in_i.opcode == OP_INSERT) && !full;
  assign ctrl.rem = accept && (in_i.opcode == OP_REMOVE) && !empty;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic  live;
    logic  prev_shift;
    data_t prev_value;
    data_t next_value;

    assign live = (CntW'(g) < cnt_q);

    if (g == 0) begin : g_first
      assign prev_shift = 1'b0;
      assign prev_value = '0;
    end else begin : g_mid
      assign prev_shift = shift[g-1];
      assign prev_value = value[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign next_value = value[g];
    end else begin : g_nxt
      assign next_value = value[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .live_i       (live),
      .item_i       (in_i.item_value),
      .prev_shift_i (prev_shift),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .shift_o      (shift[g]),
      .value_o      (value[g])
    );
  end

  always_comb begin
    cnt_d     = cnt_q;
    status_d  = STAT_DONE;
    removed_d = '0;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d     = cnt_q - CntW'(1);
      removed_d = value[0];
    end
    if (in_i.opcode == OP_INSERT && full) begin
      status_d = STAT_FULL;
    end else if (in_i.opcode == OP_REMOVE && empty) begin
      status_d = STAT_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_value = removed_q;
  assign out_o.held_count    = HeldW'(cnt_q);

endmodule

>>> rtl/spq_checker.sv
// Port-level checks on sorted_priority_queue, attached by bind.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [1:0]                status_i,
  input spq_pkg::data_t            removed_i,
  input logic [spq_pkg::HeldW-1:0] held_i
);
  import spq_pkg::*;

  // A stalled response word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(removed_i) && $stable(held_i))
    else $error("response word changed while stalled");

  // Every accepted request gives a response word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no response after accepted request");

  // Empty status means nothing held and nothing returned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_EMPTY |->
      held_i == '0 && removed_i == '0)
    else $error("empty status with data");

  // Full status only when the store is at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_FULL |->
      held_i == HeldW'(Depth) && removed_i == '0)
    else $error("full status below capacity");

  // Count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> held_i <= HeldW'(Depth))
    else $error("held count above depth");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .removed_i   (out_o.removed_value),
  .held_i      (out_o.held_count)
);
